@@ sv/srce_pkg.sv @@
// ----------------------------------------------------------------------------
// srce_pkg
// Shared types and constants for the small RISC core execute block: opcodes,
// decoded operation classes and the record passed from decode to execute.
// ----------------------------------------------------------------------------
`default_nettype none

package srce_pkg;

  localparam int XLEN        = 32;
  localparam int REG_COUNT   = 32;
  localparam int REG_IDX_W   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] OPC_ADD  = 7'd1;
  localparam logic [6:0] OPC_ADDI = 7'd2;
  localparam logic [6:0] OPC_BEQ  = 7'd3;
  localparam logic [6:0] OPC_BLTU = 7'd4;
  localparam logic [6:0] OPC_CALL = 7'd5;
  localparam logic [6:0] OPC_J    = 7'd6;
  localparam logic [6:0] OPC_LI   = 7'd7;
  localparam logic [6:0] OPC_LUI  = 7'd8;
  localparam logic [6:0] OPC_MV   = 7'd9;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd1;
  localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd0;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_ADDI,
    OP_BEQ,
    OP_BLTU,
    OP_CALL,
    OP_J,
    OP_LI,
    OP_LUI,
    OP_MV,
    OP_ILLEGAL
  } op_t;

  // imm carries whatever constant the class needs: sign-extended imm12,
  // branch/jump offset with bit 0 cleared, or the masked upper immediate
  typedef struct packed {
    op_t                  op;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs_a;
    logic [REG_IDX_W-1:0] rs_b;
    logic [XLEN-1:0]      imm;
  } dec_t;

endpackage

`default_nettype wire

@@ sv/srce_instr_if.sv @@
// ----------------------------------------------------------------------------
// srce_instr_if
// Instruction channel: valid/ready handshake carrying one instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

interface srce_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

`default_nettype wire

@@ sv/srce_result_if.sv @@
// ----------------------------------------------------------------------------
// srce_result_if
// Result channel: valid/ready handshake carrying one execution result.
// ----------------------------------------------------------------------------
`default_nettype none

interface srce_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_addr;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  dest_reg;
  logic [31:0] write_value;
  logic        taken;
  logic        halted;

  modport source (output valid, output instr_addr, output next_pc, output reg_write,
                  output dest_reg, output write_value, output taken, output halted,
                  input ready);
  modport sink   (input valid, input instr_addr, input next_pc, input reg_write,
                  input dest_reg, input write_value, input taken, input halted,
                  output ready);
endinterface

`default_nettype wire

@@ sv/srce_decode.sv @@
// ----------------------------------------------------------------------------
// srce_decode
// Front end: takes instruction words, classifies the opcode and extracts
// register indexes and the immediate into a decoded record.
// ----------------------------------------------------------------------------
`default_nettype none

module srce_decode (
  srce_instr_if.sink       instr,
  output logic             dec_valid,
  input  logic             dec_ready,
  output srce_pkg::dec_t   dec
);

  logic [31:0] w;
  logic [31:0] imm12;
  logic [31:0] boff;
  logic [31:0] joff;
  logic [31:0] upper;

  assign w     = instr.instr_word;
  assign imm12 = {{20{w[31]}}, w[31:20]};
  assign boff  = {{19{w[31]}}, w[31:20], 1'b0};
  assign joff  = {{11{w[31]}}, w[31:12], 1'b0};
  assign upper = {w[31:12], 12'd0};

  assign dec_valid   = instr.valid;
  assign instr.ready = dec_ready;

  always_comb begin
    dec.rd   = w[11:7];
    dec.rs_a = w[16:12];
    dec.rs_b = w[31:27];
    dec.imm  = imm12;
    unique case (w[6:0])
      srce_pkg::OPC_ADD:  dec.op = srce_pkg::OP_ADD;
      srce_pkg::OPC_ADDI: dec.op = srce_pkg::OP_ADDI;
      srce_pkg::OPC_BEQ: begin
        dec.op   = srce_pkg::OP_BEQ;
        dec.rs_a = w[11:7];
        dec.rs_b = w[16:12];
        dec.imm  = boff;
      end
      srce_pkg::OPC_BLTU: begin
        dec.op   = srce_pkg::OP_BLTU;
        dec.rs_a = w[11:7];
        dec.rs_b = w[16:12];
        dec.imm  = boff;
      end
      srce_pkg::OPC_CALL: begin
        dec.op  = srce_pkg::OP_CALL;
        dec.rd  = srce_pkg::LINK_REG;
        dec.imm = joff;
      end
      srce_pkg::OPC_J: begin
        dec.op  = srce_pkg::OP_J;
        dec.imm = joff;
      end
      srce_pkg::OPC_LI:  dec.op = srce_pkg::OP_LI;
      srce_pkg::OPC_LUI: begin
        dec.op  = srce_pkg::OP_LUI;
        dec.imm = upper;
      end
      srce_pkg::OPC_MV:  dec.op = srce_pkg::OP_MV;
      default:           dec.op = srce_pkg::OP_ILLEGAL;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/srce_queue.sv @@
// ----------------------------------------------------------------------------
// srce_queue
// Short queue of decoded records between decode and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module srce_queue #(
  parameter int Depth = srce_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srce_pkg::dec_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output srce_pkg::dec_t out_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  srce_pkg::dec_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CntW'(Depth));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/srce_exec.sv @@
// ----------------------------------------------------------------------------
// srce_exec
// Back end: register file, program counter and halt flag. Pulls decoded
// records from the queue, reads operands, executes, and holds the result in
// an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srce_exec (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  srce_pkg::dec_t q_data,
  srce_result_if.source  result
);

  // register file: two registered reads, one write
  logic [31:0] rf_mem [srce_pkg::REG_COUNT];
  logic [srce_pkg::REG_COUNT-1:0] rf_vld;

  // execute stage
  logic           x_valid;
  srce_pkg::dec_t x_dec;
  logic [31:0]    rdat_a;
  logic [31:0]    rdat_b;
  logic           rvld_a;
  logic           rvld_b;

  // most recent committed write, covers the read that raced it
  logic           lw_valid;
  logic [4:0]     lw_rd;
  logic [31:0]    lw_val;

  logic [31:0]    pc;
  logic           stopped;

  logic           out_valid;
  logic [31:0]    out_instr_addr;
  logic [31:0]    out_next_pc;
  logic           out_reg_write;
  logic [4:0]     out_dest_reg;
  logic [31:0]    out_write_value;
  logic           out_taken;
  logic           out_halted;

  logic           fire;
  logic           adv;
  logic [31:0]    op_a;
  logic [31:0]    op_b;
  logic [31:0]    pc_plus4;
  logic [31:0]    target;
  logic           wr;
  logic [4:0]     rd;
  logic [31:0]    val;
  logic           tk;
  logic [31:0]    pc_next;
  logic           stopped_next;
  logic           wr_eff;

  assign fire    = x_valid && (!out_valid || result.ready);
  assign q_ready = !x_valid || fire;
  assign adv     = q_valid && q_ready;

  assign op_a = (lw_valid && lw_rd == x_dec.rs_a) ? lw_val : (rvld_a ? rdat_a : 32'd0);
  assign op_b = (lw_valid && lw_rd == x_dec.rs_b) ? lw_val : (rvld_b ? rdat_b : 32'd0);

  assign pc_plus4 = pc + 32'd4;
  assign target   = pc + x_dec.imm;

  always_comb begin
    wr           = 1'b0;
    rd           = x_dec.rd;
    val          = 32'd0;
    tk           = 1'b0;
    pc_next      = pc_plus4;
    stopped_next = stopped;
    if (stopped) begin
      pc_next = pc;
    end else begin
      unique case (x_dec.op)
        srce_pkg::OP_ADD: begin
          wr  = 1'b1;
          val = op_a + op_b;
        end
        srce_pkg::OP_ADDI: begin
          wr  = 1'b1;
          val = op_a + x_dec.imm;
        end
        srce_pkg::OP_BEQ: begin
          if (op_a == op_b) begin
            tk      = 1'b1;
            pc_next = target;
          end
        end
        srce_pkg::OP_BLTU: begin
          if (op_a < op_b) begin
            tk      = 1'b1;
            pc_next = target;
          end
        end
        srce_pkg::OP_CALL: begin
          wr      = 1'b1;
          val     = pc_plus4;
          tk      = 1'b1;
          pc_next = target;
        end
        srce_pkg::OP_J: begin
          tk      = 1'b1;
          pc_next = target;
        end
        srce_pkg::OP_LI: begin
          wr  = 1'b1;
          val = x_dec.imm;
        end
        srce_pkg::OP_LUI: begin
          wr  = 1'b1;
          val = x_dec.imm;
        end
        srce_pkg::OP_MV: begin
          wr  = 1'b1;
          val = op_a;
        end
        default: begin
          stopped_next = 1'b1;
          pc_next      = pc;
        end
      endcase
    end
  end

  assign wr_eff = wr && (rd != srce_pkg::ZERO_REG);

  always_ff @(posedge clk) begin
    if (fire && wr_eff) begin
      rf_mem[rd] <= val;
    end
    if (adv) begin
      rdat_a <= rf_mem[q_data.rs_a];
      rdat_b <= rf_mem[q_data.rs_b];
      rvld_a <= rf_vld[q_data.rs_a];
      rvld_b <= rf_vld[q_data.rs_b];
      x_dec  <= q_data;
    end
    if (fire) begin
      out_instr_addr  <= pc;
      out_next_pc     <= pc_next;
      out_reg_write   <= wr_eff;
      out_dest_reg    <= wr_eff ? rd : srce_pkg::ZERO_REG;
      out_write_value <= wr_eff ? val : 32'd0;
      out_taken       <= tk;
      out_halted      <= stopped_next;
    end
    if (fire && wr_eff) begin
      lw_rd  <= rd;
      lw_val <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld    <= '0;
      x_valid   <= 1'b0;
      lw_valid  <= 1'b0;
      pc        <= 32'd0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        x_valid <= 1'b1;
      end else if (fire) begin
        x_valid <= 1'b0;
      end
      if (fire) begin
        pc        <= pc_next;
        stopped   <= stopped_next;
        out_valid <= 1'b1;
        if (wr_eff) begin
          rf_vld[rd] <= 1'b1;
          lw_valid   <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.instr_addr  = out_instr_addr;
  assign result.next_pc     = out_next_pc;
  assign result.reg_write   = out_reg_write;
  assign result.dest_reg    = out_dest_reg;
  assign result.write_value = out_write_value;
  assign result.taken       = out_taken;
  assign result.halted      = out_halted;

endmodule

`default_nettype wire

@@ sv/small_risc_core_execute.sv @@
// ----------------------------------------------------------------------------
// small_risc_core_execute
// Executes a custom RV32I-style subset, one instruction word per transfer,
// and reports the new pc, any register write and the halt state.
//
//   channel  | dir | modport | payload
//   ---------+-----+---------+-------------------------------------------------
//   instr    | in  | sink    | instr_word
//   result   | out | source  | instr_addr, next_pc, reg_write, dest_reg,
//            |     |         | write_value, taken, halted
//
// One instruction per cycle sustained while result ready stays high; result
// valid rises once its instruction has passed the queue, then execute with
// registered operand read. The execute stage sets the rate: pc and register
// updates commit on each fire; reset clears all register file valid bits.
// A stalled result register holds execute; the queue absorbs QueueDepth words.
// ----------------------------------------------------------------------------
`default_nettype none

module small_risc_core_execute #(
  parameter int QueueDepth = srce_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  srce_instr_if.sink    instr,
  srce_result_if.source result
);

  logic           dec_valid;
  logic           dec_ready;
  srce_pkg::dec_t dec;
  logic           q_valid;
  logic           q_ready;
  srce_pkg::dec_t q_data;

  srce_decode u_decode (
    .instr     (instr),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  srce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  srce_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .result  (result)
  );

endmodule

`default_nettype wire

@@ sv/srce_checker.sv @@
// ----------------------------------------------------------------------------
// srce_checker
// Port-level checks on the result channel of small_risc_core_execute.
// ----------------------------------------------------------------------------
`default_nettype none

module srce_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [31:0] instr_addr,
  input logic [31:0] next_pc,
  input logic        reg_write,
  input logic [4:0]  dest_reg,
  input logic [31:0] write_value,
  input logic        taken,
  input logic        halted
);

  // a stalled result must stay put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(next_pc) && $stable(instr_addr))
    else $error("result changed while stalled");

  // halted core does not move, redirect or write
  a_halt: assert property (@(posedge clk) disable iff (rst)
    valid && halted |-> next_pc == instr_addr && !taken && !reg_write)
    else $error("halted result not inert");

  a_nowr: assert property (@(posedge clk) disable iff (rst)
    valid && !reg_write |-> dest_reg == 5'd0 && write_value == 32'd0)
    else $error("write fields set without a write");

  a_wr: assert property (@(posedge clk) disable iff (rst)
    valid && reg_write |-> dest_reg != 5'd0)
    else $error("write to register zero reported");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    valid && !taken && !halted |-> next_pc == instr_addr + 32'd4)
    else $error("fall-through pc wrong");

endmodule

bind small_risc_core_execute srce_checker u_srce_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .instr_addr  (result.instr_addr),
  .next_pc     (result.next_pc),
  .reg_write   (result.reg_write),
  .dest_reg    (result.dest_reg),
  .write_value (result.write_value),
  .taken       (result.taken),
  .halted      (result.halted)
);

`default_nettype wire

@@ verif/tb_small_risc_core_execute.sv @@
// ----------------------------------------------------------------------------
// tb_small_risc_core_execute
// Self-checking bench for the execute block. It runs a directed set of
// instructions, then a long random stream of legal instructions, and ends with
// an illegal opcode and a tail of words that the halted core must ignore.
// A local model of pc, register file and halt flag predicts every result.
// ----------------------------------------------------------------------------
module tb_small_risc_core_execute;

  typedef struct packed {
    logic [31:0] instr_addr;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        taken;
    logic        halted;
  } exec_result_t;

  logic clk;
  logic rst;

  srce_instr_if  instr_ch ();
  srce_result_if result_ch ();

  small_risc_core_execute i_dut (
    .clk   (clk),
    .rst   (rst),
    .instr (instr_ch),
    .result(result_ch)
  );

  // architectural state mirrored by the predictor
  logic [31:0] core_pc;
  logic [31:0] gpr [srce_pkg::REG_COUNT];
  logic        core_halted;

  logic [31:0]  pending_words [$];
  exec_result_t expected_results [$];

  int error_count   = 0;
  int retired_count = 0;
  int write_count   = 0;
  int redirect_count = 0;
  int checked_count = 0;

  logic instr_fired = 1'b0;
  int   burst_left  = 0;
  int   gap_left    = 0;
  int   stall_mode  = 0;
  int   stall_left  = 0;

  task automatic queue_word(input logic [31:0] word);
    pending_words = {pending_words, word};
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic retire_instr(input logic [31:0] word);
    exec_result_t r;
    logic [31:0]  imm12;
    logic [31:0]  boff;
    logic [31:0]  joff;
    logic [31:0]  wval;
    logic [4:0]   rd;
    logic [4:0]   ra;
    logic [4:0]   rb;
    logic         wen;
    imm12 = {{20{word[31]}}, word[31:20]};
    boff  = {{19{word[31]}}, word[31:19]} & 32'hffff_fffe;
    joff  = {{11{word[31]}}, word[31:11]} & 32'hffff_fffe;
    rd    = word[11:7];
    ra    = word[16:12];
    rb    = word[31:27];
    wen   = 1'b0;
    wval  = '0;
    r     = '0;
    r.instr_addr = core_pc;
    r.next_pc    = core_pc + 32'd4;
    if (core_halted) begin
      r.next_pc = core_pc;
    end else begin
      case (word[6:0])
        srce_pkg::OPC_ADD: begin
          wen  = 1'b1;
          wval = gpr[ra] + gpr[rb];
        end
        srce_pkg::OPC_ADDI: begin
          wen  = 1'b1;
          wval = gpr[ra] + imm12;
        end
        srce_pkg::OPC_BEQ: begin
          if (gpr[rd] == gpr[ra]) begin
            r.taken   = 1'b1;
            r.next_pc = core_pc + boff;
          end
        end
        srce_pkg::OPC_BLTU: begin
          if (gpr[rd] < gpr[ra]) begin
            r.taken   = 1'b1;
            r.next_pc = core_pc + boff;
          end
        end
        srce_pkg::OPC_CALL: begin
          wen       = 1'b1;
          rd        = srce_pkg::LINK_REG;
          wval      = core_pc + 32'd4;
          r.taken   = 1'b1;
          r.next_pc = core_pc + joff;
        end
        srce_pkg::OPC_J: begin
          r.taken   = 1'b1;
          r.next_pc = core_pc + joff;
        end
        srce_pkg::OPC_LI: begin
          wen  = 1'b1;
          wval = imm12;
        end
        srce_pkg::OPC_LUI: begin
          wen  = 1'b1;
          wval = word & 32'hffff_f000;
        end
        srce_pkg::OPC_MV: begin
          wen  = 1'b1;
          wval = gpr[ra];
        end
        default: begin
          core_halted = 1'b1;
          r.next_pc   = core_pc;
        end
      endcase
    end
    if (wen && rd != srce_pkg::ZERO_REG) begin
      gpr[rd]       = wval;
      r.reg_write   = 1'b1;
      r.dest_reg    = rd;
      r.write_value = wval;
      write_count++;
    end
    if (r.taken) redirect_count++;
    r.halted = core_halted;
    core_pc  = r.next_pc;
    retired_count++;
    expected_results = {expected_results, r};
  endtask

  // --------------------------------------------------------------------------
  // Encoders for the directed part
  // --------------------------------------------------------------------------
  function automatic logic [31:0] fmt_i(logic [6:0] op, logic [4:0] rd, logic [4:0] rs,
                                        logic [11:0] imm);
    return {imm, 3'b000, rs, rd, op};
  endfunction

  function automatic logic [31:0] fmt_b(logic [6:0] op, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] off);
    return {off, 2'b00, rs2, rs1, op};
  endfunction

  function automatic logic [31:0] fmt_j(logic [6:0] op, logic [20:0] off, logic [3:0] low);
    return {off, low, op};
  endfunction

  function automatic logic [31:0] rand_legal_word();
    logic [31:0] w;
    logic [6:0]  op;
    int          pick;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 14)      op = srce_pkg::OPC_ADD;
    else if (pick < 28) op = srce_pkg::OPC_ADDI;
    else if (pick < 40) op = srce_pkg::OPC_BEQ;
    else if (pick < 52) op = srce_pkg::OPC_BLTU;
    else if (pick < 58) op = srce_pkg::OPC_CALL;
    else if (pick < 64) op = srce_pkg::OPC_J;
    else if (pick < 78) op = srce_pkg::OPC_LI;
    else if (pick < 86) op = srce_pkg::OPC_LUI;
    else                op = srce_pkg::OPC_MV;
    w[6:0] = op;
    // keep indices in a few low registers half the time so values chain
    if ($urandom_range(0, 1) == 1) begin
      w[11:10] = 2'b00;
      w[16:15] = 2'b00;
      if (op == srce_pkg::OPC_ADD) w[31:30] = 2'b00;
    end
    if ((op == srce_pkg::OPC_BEQ || op == srce_pkg::OPC_BLTU) && $urandom_range(0, 3) == 0)
      w[16:12] = w[11:7];
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || instr_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    result_ch.ready     = 1'b0;
    core_pc             = '0;
    core_halted         = 1'b0;
    for (int i = 0; i < srce_pkg::REG_COUNT; i++) gpr[i] = '0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every operation, writes to x0, link, wrap
    queue_word(fmt_i(srce_pkg::OPC_LI, 5'd1, 5'd0, 12'hfff));
    queue_word(fmt_i(srce_pkg::OPC_LI, 5'd2, 5'd9, 12'h7ff));
    queue_word({20'hfffff, 5'd3, srce_pkg::OPC_LUI});
    queue_word(fmt_i(srce_pkg::OPC_LUI, 5'd9, 5'd31, 12'h123));
    queue_word({5'd2, 10'h3ff, 5'd1, 5'd4, srce_pkg::OPC_ADD});
    queue_word(fmt_i(srce_pkg::OPC_ADDI, 5'd5, 5'd1, 12'h001));
    queue_word(fmt_i(srce_pkg::OPC_ADDI, 5'd0, 5'd1, 12'h005));
    queue_word(fmt_i(srce_pkg::OPC_MV, 5'd6, 5'd3, 12'habc));
    queue_word(fmt_i(srce_pkg::OPC_MV, 5'd7, 5'd0, 12'h000));
    queue_word(fmt_i(srce_pkg::OPC_LI, 5'd31, 5'd0, 12'h800));
    queue_word(fmt_i(srce_pkg::OPC_ADDI, 5'd30, 5'd31, 12'h800));
    queue_word(fmt_b(srce_pkg::OPC_BEQ, 5'd1, 5'd1, 13'h1000));
    queue_word(fmt_b(srce_pkg::OPC_BEQ, 5'd1, 5'd2, 13'h0ffe));
    queue_word(fmt_b(srce_pkg::OPC_BLTU, 5'd2, 5'd1, 13'h0fff));
    queue_word(fmt_b(srce_pkg::OPC_BLTU, 5'd1, 5'd2, 13'h0010));
    queue_word(fmt_b(srce_pkg::OPC_BLTU, 5'd7, 5'd0, 13'h1fff));
    queue_word(fmt_b(srce_pkg::OPC_BEQ, 5'd6, 5'd30, 13'h1ffe));
    queue_word(fmt_j(srce_pkg::OPC_J, 21'h0fffff, 4'hf));
    queue_word(fmt_j(srce_pkg::OPC_J, 21'h100000, 4'h0));
    queue_word(fmt_j(srce_pkg::OPC_CALL, 21'h000000, 4'h5));
    queue_word(fmt_j(srce_pkg::OPC_CALL, 21'h1fffff, 4'ha));
    queue_word(fmt_i(srce_pkg::OPC_MV, 5'd8, 5'd1, 12'h000));
    queue_word({20'h00000, 5'd0, srce_pkg::OPC_LUI});
    queue_word({5'd31, 10'h000, 5'd31, 5'd0, srce_pkg::OPC_ADD});

    // sender holds off until the directed part has fully drained
    wait_drained();

    for (int i = 0; i < 1650; i++) queue_word(rand_legal_word());
    wait_drained();

    // illegal opcode with all opcode bits set, then words the core ignores
    queue_word({$urandom} | 32'h0000_007f);
    for (int i = 0; i < 28; i++) begin
      if (i % 4 == 0) queue_word({$urandom} & 32'hffff_ff80);
      else queue_word(rand_legal_word());
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Executed %0d instructions, %0d results checked: %0d register writes,",
             retired_count, checked_count, write_count);
    $display("%0d redirects, halt flag %0d at end, final pc %08h",
             redirect_count, core_halted, core_pc);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Instruction driver: bursts of transfers separated by random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    instr_fired <= !rst && instr_ch.valid && instr_ch.ready;
    if (!rst && instr_ch.valid && instr_ch.ready) retire_instr(instr_ch.instr_word);
  end

  always @(negedge clk) begin
    if (rst) begin
      instr_ch.valid <= 1'b0;
    end else if (instr_ch.valid && !instr_fired) begin
      // word still waiting for its transfer
    end else if (gap_left != 0) begin
      instr_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() != 0) begin
      instr_ch.valid      <= 1'b1;
      instr_ch.instr_word <= pending_words.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      instr_ch.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 9) < 7);
      2: result_ch.ready <= ($urandom_range(0, 9) < 3);
      default: result_ch.ready <= (stall_left % 5 != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %08h, got %08h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    exec_result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with none expected, instr_addr %08h",
                 $realtime, result_ch.instr_addr);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        checked_count++;
        check_field("instr_addr", exp_r.instr_addr, result_ch.instr_addr);
        check_field("next_pc", exp_r.next_pc, result_ch.next_pc);
        check_field("reg_write", 32'(exp_r.reg_write), 32'(result_ch.reg_write));
        check_field("dest_reg", 32'(exp_r.dest_reg), 32'(result_ch.dest_reg));
        check_field("write_value", exp_r.write_value, result_ch.write_value);
        check_field("taken", 32'(exp_r.taken), 32'(result_ch.taken));
        check_field("halted", 32'(exp_r.halted), 32'(result_ch.halted));
      end
    end
  end

endmodule
